FILE: sv/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define VAO_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("voice allocator check failed");

// Same-cycle implication.
`define VAO_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voice allocator implication failed");

// Next-cycle implication.
`define VAO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voice allocator sequence failed");

`endif

FILE: sv/vao_pkg.sv
// Shared types, constants and helpers of the voice allocator.
// No dependencies; imported by every module of the block but the generic RAM.
package vao_pkg;

    localparam int VOICES    = 24;
    localparam int VIDX_W    = $clog2(VOICES);
    localparam int CNT_W     = $clog2(VOICES + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [30:0] TIME_MAX = 31'h7fff_ffff;
    localparam logic [3:0]  CHAN_ANY = 4'hf;
    localparam logic [3:0]  CHAN_ZERO = 4'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIENT_ENTITY  = 1'b0,
        CFG_STREAM_CHANNEL = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_KEPT     = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    // Stored part of one voice (lives in RAM)
    typedef struct packed {
        logic [15:0] entity;
        logic [3:0]  channel;
        logic [11:0] sound;
        logic [30:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Voice as seen by the scan: RAM entry plus active flag
    typedef struct packed {
        logic   active;
        entry_t entry;
    } voice_t;

    // Latched start request
    typedef struct packed {
        logic [15:0] entity;
        logic [3:0]  channel;
        logic [11:0] sound;
        logic        loops;
        logic [30:0] time_ms;
    } req_t;

    // Scan control from sequencer to picker
    typedef struct packed {
        logic              clear;
        logic              eval;
        logic [VIDX_W-1:0] idx;
    } scan_ctl_t;

    // Picker status back to sequencer
    typedef struct packed {
        logic              found;
        logic [VIDX_W-1:0] idx;
        voice_t            best;
    } pick_t;

    // Low five bits of a voice index for the result field
    function automatic logic [4:0] voice_field(logic [VIDX_W-1:0] idx);
        logic [VIDX_W+4:0] w;
        w = {5'b0, idx};
        return w[4:0];
    endfunction

endpackage

FILE: sv/vao_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module vao_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/vao_store.sv
// Voice store: RAM for per-voice fields, flops for active and written flags.
// Depends on vao_pkg and vao_ram.
module vao_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [vao_pkg::VIDX_W-1:0] rd_addr,
    output vao_pkg::voice_t            rd_voice,
    input  logic                       wr_en,
    input  logic [vao_pkg::VIDX_W-1:0] wr_addr,
    input  vao_pkg::entry_t            wr_entry,
    input  logic                       rel_en,
    input  logic [vao_pkg::VIDX_W-1:0] rel_addr
);
    import vao_pkg::*;

    logic [VOICES-1:0]  active_reg;
    logic [VOICES-1:0]  written_reg;
    logic               rd_active_reg;
    logic               rd_written_reg;
    logic [ENTRY_W-1:0] ram_q;

    vao_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VOICES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Flags: reset clears; an entry never written reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            written_reg    <= '0;
            rd_active_reg  <= 1'b0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (rel_en)
            begin
                active_reg[rel_addr] <= 1'b0;
            end
            if (wr_en)
            begin
                active_reg[wr_addr]  <= 1'b1;
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_active_reg  <= active_reg[rd_addr];
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_voice.active = rd_active_reg;
        rd_voice.entry  = rd_written_reg ? entry_t'(ram_q) : '0;
    end

endmodule

FILE: sv/vao_pick.sv
// Scan evaluator: checks one voice per cycle and tracks the winner.
// Depends on vao_pkg.
module vao_pick (
    input  logic                clk,
    input  logic                rst_n,
    input  vao_pkg::scan_ctl_t  ctl,
    input  vao_pkg::voice_t     voice_in,
    input  vao_pkg::req_t       req,
    input  logic [15:0]         client_entity,
    input  logic [2:0]          stream_channel,
    output vao_pkg::pick_t      pick
);
    import vao_pkg::*;

    logic              found_reg, found_next;
    logic              hit_reg, hit_next;
    logic [VIDX_W-1:0] idx_reg, idx_next;
    voice_t            best_reg, best_next;
    logic [30:0]       oldest_reg, oldest_next;

    logic skip_stream;
    logic same_owner;
    logic protect;
    logic older;

    // Per-voice tests
    always_comb
    begin
        skip_stream = voice_in.active
                      && (voice_in.entry.channel == {1'b0, stream_channel});
        same_owner  = (req.channel != CHAN_ZERO)
                      && (voice_in.entry.entity == req.entity)
                      && ((voice_in.entry.channel == req.channel)
                          || (req.channel == CHAN_ANY));
        protect     = (req.entity != client_entity)
                      && (voice_in.entry.entity == client_entity);
        older       = voice_in.entry.start < oldest_reg;
    end

    // Winner update; a same-owner hit freezes the rest of the scan
    always_comb
    begin
        found_next  = found_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        oldest_next = oldest_reg;
        if (ctl.clear)
        begin
            found_next  = 1'b0;
            hit_next    = 1'b0;
            oldest_next = TIME_MAX;
        end
        else if (ctl.eval && !hit_reg && !skip_stream)
        begin
            if (same_owner)
            begin
                found_next = 1'b1;
                hit_next   = 1'b1;
                idx_next   = ctl.idx;
                best_next  = voice_in;
            end
            else if (!protect && older)
            begin
                found_next  = 1'b1;
                idx_next    = ctl.idx;
                best_next   = voice_in;
                oldest_next = voice_in.entry.start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            oldest_reg <= TIME_MAX;
        end
        else
        begin
            found_reg  <= found_next;
            hit_reg    <= hit_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
    end

    always_comb
    begin
        pick.found = found_reg;
        pick.idx   = idx_reg;
        pick.best  = best_reg;
    end

endmodule

FILE: sv/voice_allocator_oldest_steal.sv
// Voice allocator with oldest-first stealing, top level and sequencer.
// Start: the scan reads one RAM entry per cycle, then a decide state picks the result and
// writes the winner back; a release goes straight to the result. One item in flight: a new
// request is taken only once the result has moved to the output register, which waits while full.
// Reset clears control, flags and config (client 0, stream 5).
// Depends on vao_pkg, vao_store and vao_pick.
module voice_allocator_oldest_steal (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          func,
    input  logic [15:0]                   entity,
    input  logic signed [3:0]             ent_channel,
    input  logic [11:0]                   sound_id,
    input  logic                          sound_loops,
    input  logic [30:0]                   time_ms,
    input  logic [4:0]                    voice_index,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [1:0]                    status,
    output logic [4:0]                    voice,
    output logic                          preempted,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vao_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import vao_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [VIDX_W-1:0] eval_idx_reg, eval_idx_next;
    req_t              req_reg, req_next;
    status_t           res_status_reg, res_status_next;
    logic [4:0]        res_voice_reg, res_voice_next;
    logic              res_pre_reg, res_pre_next;
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           status_reg, status_next;
    logic [4:0]        voice_reg, voice_next;
    logic              preempted_reg, preempted_next;
    logic [15:0]       client_entity_reg;
    logic [2:0]        stream_channel_reg;

    logic              req_xfer;
    logic              rd_en;
    logic              wr_en;
    logic              rel_en;
    logic              same_loop;
    voice_t            rd_voice;
    entry_t            wr_entry;
    scan_ctl_t         ctl;
    pick_t             pick;

    // Configuration registers; written only with no item in flight
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_entity_reg  <= 16'd0;
            stream_channel_reg <= 3'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CLIENT_ENTITY:  client_entity_reg  <= cfg_data;
                CFG_STREAM_CHANNEL: stream_channel_reg <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    // A pending register write goes first
    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign req_xfer  = req_valid && req_ready;

    // Store and picker
    assign rel_en = req_xfer && func && (32'(voice_index) < 32'(VOICES));

    always_comb
    begin
        wr_entry.entity  = req_reg.entity;
        wr_entry.channel = req_reg.channel;
        wr_entry.sound   = req_reg.sound;
        wr_entry.start   = req_reg.time_ms;
    end

    vao_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_cnt_reg[VIDX_W-1:0]),
        .rd_voice (rd_voice),
        .wr_en    (wr_en),
        .wr_addr  (pick.idx),
        .wr_entry (wr_entry),
        .rel_en   (rel_en),
        .rel_addr (VIDX_W'(voice_index))
    );

    always_comb
    begin
        ctl.clear = req_xfer && !func;
        ctl.eval  = eval_valid_reg;
        ctl.idx   = eval_idx_reg;
    end

    vao_pick u_pick (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .voice_in       (rd_voice),
        .req            (req_reg),
        .client_entity  (client_entity_reg),
        .stream_channel (stream_channel_reg),
        .pick           (pick)
    );

    // Busy winner playing the same looping sound is left alone
    assign same_loop = pick.best.active && req_reg.loops
                       && (pick.best.entry.entity == req_reg.entity)
                       && (pick.best.entry.channel == req_reg.channel)
                       && (pick.best.entry.sound == req_reg.sound);

    // Sequencer: next state, scan reads, write-back and result
    always_comb
    begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = eval_idx_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_voice_next  = res_voice_reg;
        res_pre_next    = res_pre_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;
        voice_next      = voice_reg;
        preempted_next  = preempted_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    if (func)
                    begin
                        res_status_next = ST_RELEASED;
                        res_voice_next  = voice_index;
                        res_pre_next    = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        req_next.entity  = entity;
                        req_next.channel = ent_channel;
                        req_next.sound   = sound_id;
                        req_next.loops   = sound_loops;
                        req_next.time_ms = time_ms;
                        rd_cnt_next      = '0;
                        state_next       = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en = (rd_cnt_reg < CNT_W'(VOICES));
                if (rd_en)
                begin
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                    eval_valid_next = 1'b1;
                    eval_idx_next   = rd_cnt_reg[VIDX_W-1:0];
                end
                if (eval_valid_reg && (eval_idx_reg == VIDX_W'(VOICES - 1)))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_pre_next = 1'b0;
                if (!pick.found)
                begin
                    res_status_next = ST_DROPPED;
                    res_voice_next  = 5'd0;
                end
                else if (same_loop)
                begin
                    res_status_next = ST_KEPT;
                    res_voice_next  = voice_field(pick.idx);
                end
                else
                begin
                    wr_en           = 1'b1;
                    res_status_next = ST_STARTED;
                    res_voice_next  = voice_field(pick.idx);
                    res_pre_next    = pick.best.active;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand over once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    voice_next     = res_voice_reg;
                    preempted_next = res_pre_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_cnt_reg     <= '0;
            eval_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            eval_valid_reg <= eval_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_voice_reg  <= res_voice_next;
        res_pre_reg    <= res_pre_next;
        status_reg     <= status_next;
        voice_reg      <= voice_next;
        preempted_reg  <= preempted_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign voice     = voice_reg;
    assign preempted = preempted_reg;

endmodule

FILE: sv/vao_checker.sv
// Port-level checks of the voice allocator, bound to the top level.
// Depends on vao_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vao_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          func,
    input logic [15:0]                   entity,
    input logic signed [3:0]             ent_channel,
    input logic [11:0]                   sound_id,
    input logic                          sound_loops,
    input logic [30:0]                   time_ms,
    input logic [4:0]                    voice_index,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [1:0]                    status,
    input logic [4:0]                    voice,
    input logic                          preempted,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [vao_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [15:0]                   cfg_data
);
    import vao_pkg::*;

    // One item at a time: a transfer closes the input until its result is out
    `VAO_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // A dropped request names no voice and stops nothing
    `VAO_ASSERT_IMPL(a_drop_clean, clk, rst_n, rsp_valid && (status == ST_DROPPED), (voice == 5'd0) && !preempted)

    // Only a fresh start can preempt
    `VAO_ASSERT_IMPL(a_pre_only_start, clk, rst_n, rsp_valid && preempted, status == ST_STARTED)

    // A started or kept voice lies inside the pool
    `VAO_ASSERT_IMPL(a_voice_range, clk, rst_n, rsp_valid && ((status == ST_STARTED) || (status == ST_KEPT)), 32'(voice) < 32'(VOICES))

    // Result holds until taken
    `VAO_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(voice) && $stable(preempted))

endmodule

bind voice_allocator_oldest_steal vao_checker u_vao_checker (.*);

FILE: tb/alloc_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard of the voice allocator: keeps its own copy of the voice pool,
// predicts one grant per accepted request and checks results in order.
// Depends on vao_pkg.
package alloc_check_pkg;
    import vao_pkg::*;

    // One expected result of the allocator
    typedef struct packed {
        status_t    status;
        logic [4:0] voice;
        logic       preempted;
    } grant_t;

    class alloc_scoreboard;
        // Voice pool as the block should hold it
        logic        busy  [VOICES];
        logic [15:0] owner [VOICES];
        logic [3:0]  chan  [VOICES];
        logic [11:0] sound [VOICES];
        logic [30:0] stamp [VOICES];
        logic [15:0] client;
        logic [2:0]  stream;

        grant_t pending[$];
        int     errors;
        int     n_items, n_started, n_preempted, n_dropped, n_kept, n_released;

        function new();
            for (int i = 0; i < VOICES; i++)
            begin
                busy[i]  = 1'b0;
                owner[i] = '0;
                chan[i]  = '0;
                sound[i] = '0;
                stamp[i] = '0;
            end
            client = '0;
            stream = 3'd5;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            if (idx == CFG_CLIENT_ENTITY)
                client = data;
            else
                stream = data[2:0];
        endfunction

        // Accepted request: update the pool and queue the grant it must give
        function void note_item(logic f, logic [15:0] ent, logic [3:0] ch,
                                logic [11:0] snd, logic lp, logic [30:0] t,
                                logic [4:0] vidx);
            grant_t      g;
            int          best;
            logic [30:0] oldest;
            best       = -1;
            oldest     = TIME_MAX;
            g.preempted = 1'b0;
            n_items++;
            if (f)
            begin
                if (vidx < VOICES)
                    busy[vidx] = 1'b0;
                g.status = ST_RELEASED;
                g.voice  = vidx;
                n_released++;
            end
            else
            begin
                // Scan in index order: stream voices skipped, own channel taken
                // at once, client voices protected, else strictly oldest wins
                for (int i = 0; i < VOICES; i++)
                begin
                    if (busy[i] && chan[i] == {1'b0, stream})
                        continue;
                    if (ch != CHAN_ZERO && owner[i] == ent &&
                        (chan[i] == ch || ch == CHAN_ANY))
                    begin
                        best = i;
                        break;
                    end
                    if (ent != client && owner[i] == client)
                        continue;
                    if (stamp[i] < oldest)
                    begin
                        oldest = stamp[i];
                        best   = i;
                    end
                end
                if (best < 0)
                begin
                    g.status = ST_DROPPED;
                    g.voice  = '0;
                    n_dropped++;
                end
                else if (busy[best] && lp && owner[best] == ent &&
                         chan[best] == ch && sound[best] == snd)
                begin
                    // same looping sound keeps playing
                    g.status = ST_KEPT;
                    g.voice  = 5'(best);
                    n_kept++;
                end
                else
                begin
                    g.status    = ST_STARTED;
                    g.voice     = 5'(best);
                    g.preempted = busy[best];
                    busy[best]  = 1'b1;
                    owner[best] = ent;
                    chan[best]  = ch;
                    sound[best] = snd;
                    stamp[best] = t;
                    n_started++;
                    if (g.preempted)
                        n_preempted++;
                end
            end
            pending.push_back(g);
        endfunction

        function void check_result(logic [1:0] st, logic [4:0] v, logic p);
            grant_t g;
            if (pending.size() == 0)
            begin
                $error("result with no request waiting: status %0d voice %0d preempted %0d",
                       st, v, p);
                errors++;
                return;
            end
            g = pending.pop_front();
            if (st !== g.status)
            begin
                $error("status: expected %0d, got %0d", g.status, st);
                errors++;
            end
            if (v !== g.voice)
            begin
                $error("voice: expected %0d, got %0d", g.voice, v);
                errors++;
            end
            if (p !== g.preempted)
            begin
                $error("preempted: expected %0d, got %0d", g.preempted, p);
                errors++;
            end
        endfunction
    endclass
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of voice_allocator_oldest_steal: directed and random
// start and release requests under several register settings and stalls.
// Depends on vao_pkg, alloc_check_pkg and the allocator RTL.
module testbench;
    import vao_pkg::*;
    import alloc_check_pkg::*;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 150;
    localparam int unsigned TIME_TOP     = 2147483646;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    logic        func        = 1'b0;
    logic [15:0] entity      = '0;
    logic [3:0]  ent_channel = '0;
    logic [11:0] sound_id    = '0;
    logic        sound_loops = 1'b0;
    logic [30:0] time_ms     = '0;
    logic [4:0]  voice_index = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    logic [1:0]  status;
    logic [4:0]  voice;
    logic        preempted;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data    = '0;

    alloc_scoreboard board;

    // Idle percentages of sender and receiver
    int          send_idle  = 29;
    int          take_idle  = 67;
    int          quiet_cycles = 0;
    int          settings   = 0;
    int unsigned clock_ms;
    logic [15:0] client_now = '0;

    // Register settings and idling of the random phases
    logic [15:0] phase_client [PHASES] = '{16'h0001, 16'h0000, 16'hffff,
                                           16'h0002, 16'h8000, 16'h0003};
    logic [2:0]  phase_stream [PHASES] = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2};
    int          idle_send    [3]      = '{29, 67, 0};
    int          idle_take    [3]      = '{67, 29, 0};

    voice_allocator_oldest_steal dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .entity      (entity),
        .ent_channel (ent_channel),
        .sound_id    (sound_id),
        .sound_loops (sound_loops),
        .time_ms     (time_ms),
        .voice_index (voice_index),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .voice       (voice),
        .preempted   (preempted),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver stalls
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= take_idle);

    // Result check
    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(status, voice, preempted);

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One request transfer; valid stays high afterwards unless the next
    // item idles first or the caller drops it
    task automatic send_item(input logic f, input logic [15:0] ent,
                             input logic [3:0] ch, input logic [11:0] snd,
                             input logic lp, input logic [30:0] t,
                             input logic [4:0] vidx);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        func        <= f;
        entity      <= ent;
        ent_channel <= ch;
        sound_id    <= snd;
        sound_loops <= lp;
        time_ms     <= t;
        voice_index <= vidx;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_item(f, ent, ch, snd, lp, t, vidx);
    endtask

    task automatic start_req(input logic [15:0] ent, input logic [3:0] ch,
                             input logic [11:0] snd, input logic lp,
                             input logic [30:0] t);
        send_item(1'b0, ent, ch, snd, lp, t, 5'($urandom));
    endtask

    // Release with junk in the unused fields
    task automatic free_voice(input logic [4:0] vidx);
        send_item(1'b1, 16'($urandom), 4'($urandom), 12'($urandom), 1'($urandom),
                  31'($urandom_range(TIME_TOP)), vidx);
    endtask

    // Both registers back to back, only with the block idle
    task automatic load_regs(input logic [15:0] client, input logic [2:0] stream);
        logic [15:0] stream_word;
        stream_word = {13'($urandom), stream};
        req_valid  <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLIENT_ENTITY;
        cfg_data  <= client;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(CFG_CLIENT_ENTITY, client);
        cfg_index <= CFG_STREAM_CHANNEL;
        cfg_data  <= stream_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(CFG_STREAM_CHANNEL, stream_word);
        cfg_valid  <= 1'b0;
        client_now = client;
        settings++;
    endtask

    // Mostly plausible starts from a few entities, some releases, some noise
    task automatic random_item();
        int          pick;
        logic [15:0] ent;
        logic [3:0]  ch;
        pick = $urandom_range(99);
        if (pick < 25)
            free_voice((pick < 3) ? 5'($urandom_range(31, VOICES))
                                  : 5'($urandom_range(VOICES - 1)));
        else if (pick < 35)
            start_req(16'($urandom), 4'($urandom), 12'($urandom), 1'($urandom),
                      31'($urandom_range(TIME_TOP)));
        else
        begin
            case ($urandom_range(4))
                0, 1: ent = client_now;
                2: ent = 16'h0001;
                3: ent = 16'h0002;
                default: ent = 16'h0003;
            endcase
            pick = $urandom_range(9);
            if (pick < 8)
                ch = 4'(pick);
            else if (pick == 8)
                ch = CHAN_ANY;
            else
                ch = 4'($urandom_range(14, 8));
            clock_ms += $urandom_range(40);
            start_req(ent, ch, 12'($urandom_range(3)), 1'($urandom), 31'(clock_ms));
        end
    endtask

    initial
    begin
        board    = new();
        clock_ms = $urandom_range(1000);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values: every voice belongs to the client
        start_req(16'h0007, 4'd1, 12'h001, 1'b0, 31'd10);   // outsider dropped
        start_req(16'h0000, 4'd1, 12'hfff, 1'b1, 31'd0);
        start_req(16'h0000, 4'd1, 12'hfff, 1'b1, 31'd20);   // loop kept
        start_req(16'h0000, 4'd1, 12'hfff, 1'b0, 31'd30);   // same channel preempt
        start_req(16'h0000, CHAN_ANY, 12'h005, 1'b0, 31'd40);
        start_req(16'h0000, CHAN_ZERO, 12'h006, 1'b0, 31'd50);
        start_req(16'h0000, 4'd5, 12'h007, 1'b1, 31'd60);   // lands on stream channel
        start_req(16'h0000, 4'd5, 12'h007, 1'b1, 31'd70);   // stream voice skipped
        start_req(16'h0000, 4'h8, 12'h000, 1'b0, 31'(TIME_TOP));
        start_req(16'h0000, 4'h8, 12'habc, 1'b1, 31'd80);   // other negative channel
        free_voice(5'd0);
        start_req(16'h0000, CHAN_ANY, 12'h005, 1'b0, 31'd90); // idle voice reused
        free_voice(5'd23);
        free_voice(5'd24);                                  // beyond the pool
        free_voice(5'd31);

        // Directed, client at the top, stream channel 0
        load_regs(16'hffff, 3'd0);
        start_req(16'hffff, 4'd7, 12'h123, 1'b1, 31'h2aaa_aaaa);
        start_req(16'h0001, 4'd7, 12'h456, 1'b0, 31'd95);
        start_req(16'hffff, 4'd7, 12'h123, 1'b1, 31'd100);
        start_req(16'hffff, 4'd2, 12'h555, 1'b0, 31'h5555_5555);
        start_req(16'h0001, CHAN_ZERO, 12'h789, 1'b1, 31'd110);
        free_voice(5'd10);

        // Random phases
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle = idle_send[p % 3];
            take_idle = idle_take[p % 3];
            load_regs(phase_client[p], phase_stream[p]);
            repeat (PHASE_ITEMS)
                random_item();
        end
        req_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d requests under %0d register settings: %0d started (%0d preempting),",
                 board.n_items, settings, board.n_started, board.n_preempted);
        $display("%0d dropped, %0d loops kept, %0d releases; %0d mismatches",
                 board.n_dropped, board.n_kept, board.n_released, board.errors);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
